/* hw/rtl/sbfr_pkg.sv */
// ----------------------------------------------------------------------------
// Frame receiver package
// Types, constants and register indexes shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package sbfr_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int IDX_W       = 5;
  localparam int CHAN_W      = 11;
  localparam int CFG_INDEX_W = 3;

  typedef logic [7:0]        byte_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [IDX_W-1:0]  index_t;

  localparam byte_t  HEADER_BYTE  = 8'h0F;
  localparam chan_t  CHAN_RESET   = 11'd1000;
  localparam byte_t  COUNT_MAX    = 8'hFF;
  localparam index_t LAST_INDEX   = IDX_W'(FRAME_BYTES - 1);

  localparam byte_t FOOTER_FIRST_RESET  = 8'h02;
  localparam byte_t FOOTER_SECOND_RESET = 8'h00;
  localparam byte_t FAILSAFE_RESET      = 8'h0C;
  localparam byte_t LOSS_LIMIT_RESET    = 8'd100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FOOTER_FIRST  = 3'd0,
    REG_FOOTER_SECOND = 3'd1,
    REG_FAILSAFE_CODE = 3'd2,
    REG_LOSS_LIMIT    = 3'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       frame_done;
    chan_t      chan_zero;
    chan_t      chan_one;
    chan_t      chan_two;
    chan_t      chan_three;
    logic [3:0] left_switch_pos;
    logic [4:0] right_switch_pos;
    byte_t      wheel_value;
    logic       link_ok;
  } result_t;

endpackage

/* hw/rtl/sbfr_byte_cell.sv */
// ----------------------------------------------------------------------------
// Frame byte cell
// One byte of frame storage that takes its neighbour's byte on each shift.
// ----------------------------------------------------------------------------
module sbfr_byte_cell (
  input  logic            clk,
  input  logic            shift,
  input  sbfr_pkg::byte_t d,
  output sbfr_pkg::byte_t q
);
  import sbfr_pkg::*;

  byte_t data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  assign q = data;

endmodule

/* hw/rtl/sbfr_byte_chain.sv */
// ----------------------------------------------------------------------------
// Frame byte chain
// A row of byte cells; each frame byte enters the first cell and moves one
// cell further with every following frame byte.
// ----------------------------------------------------------------------------
module sbfr_byte_chain (
  input  logic            clk,
  input  logic            shift,
  input  sbfr_pkg::byte_t din,
  output sbfr_pkg::byte_t taps [sbfr_pkg::FRAME_BYTES]
);
  import sbfr_pkg::*;

  byte_t links [FRAME_BYTES+1];

  assign links[0] = din;

  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    sbfr_byte_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (links[i]),
      .q     (links[i+1])
    );
    assign taps[i] = links[i+1];
  end

endmodule

/* hw/rtl/sbus_frame_receiver.sv */
// ----------------------------------------------------------------------------
// Frame receiver
// Hunts for the header, shifts the frame bytes through a chain of byte cells,
// checks the footer and unpacks channels, switches, wheel and link state.
// ----------------------------------------------------------------------------
// An accepted word's result word is registered in the output register, or in
// the skid register while the output is held. Throughput: one word per cycle
// while the skid register is empty; the two registers let a new word enter while a result is still waiting.
// Reset clears control state, loads the register defaults and sets the held
// channels to 1000; the frame cells are not cleared.
module sbus_frame_receiver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sbfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [7:0]                          cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                cmd,
  input  logic [7:0]                          rx_byte,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                frame_done,
  output logic [10:0]                         chan_zero,
  output logic [10:0]                         chan_one,
  output logic [10:0]                         chan_two,
  output logic [10:0]                         chan_three,
  output logic [3:0]                          left_switch_pos,
  output logic [4:0]                          right_switch_pos,
  output logic [7:0]                          wheel_value,
  output logic                                link_ok
);
  import sbfr_pkg::*;

  byte_t footer_first, footer_second, failsafe_code, loss_limit;

  logic   in_frame, in_frame_next;
  index_t byte_index, byte_index_next;
  byte_t  loss_count, loss_count_next;
  logic   link_alive, link_alive_next;
  chan_t  chan_held [4];
  chan_t  chan_held_next [4];
  logic [3:0] left_held, left_held_next;
  logic [4:0] right_held, right_held_next;
  byte_t      wheel_held, wheel_held_next;
  logic       done_next;

  logic    accept, shift;
  byte_t   taps [FRAME_BYTES];
  byte_t   fb [FRAME_BYTES-1];
  byte_t   count_inc;
  result_t result_next, main_word, skid_word;
  logic    skid_valid;

  assign accept     = item_valid && !item_stall;
  assign item_stall = skid_valid;
  assign shift      = accept && (cmd == CMD_BYTE) && in_frame;

  sbfr_byte_chain u_chain (
    .clk   (clk),
    .shift (shift),
    .din   (rx_byte),
    .taps  (taps)
  );

  // Before the final byte shifts in, frame byte k sits in cell FRAME_BYTES-2-k.
  for (genvar k = 0; k < FRAME_BYTES - 1; k++) begin : g_fb
    assign fb[k] = taps[FRAME_BYTES-2-k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      footer_first  <= FOOTER_FIRST_RESET;
      footer_second <= FOOTER_SECOND_RESET;
      failsafe_code <= FAILSAFE_RESET;
      loss_limit    <= LOSS_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOOTER_FIRST:  footer_first  <= cfg_data;
        REG_FOOTER_SECOND: footer_second <= cfg_data;
        REG_FAILSAFE_CODE: failsafe_code <= cfg_data;
        REG_LOSS_LIMIT:    loss_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count_inc = (loss_count == COUNT_MAX) ? COUNT_MAX : loss_count + 8'd1;

  always_comb begin
    in_frame_next   = in_frame;
    byte_index_next = byte_index;
    loss_count_next = loss_count;
    link_alive_next = link_alive;
    chan_held_next  = chan_held;
    left_held_next  = left_held;
    right_held_next = right_held;
    wheel_held_next = wheel_held;
    done_next       = 1'b0;
    if (cmd == CMD_TICK) begin
      if (count_inc > loss_limit) begin
        loss_count_next = loss_limit;
        link_alive_next = 1'b0;
      end else begin
        loss_count_next = count_inc;
      end
    end else if (!in_frame) begin
      if (rx_byte == HEADER_BYTE) begin
        in_frame_next   = 1'b1;
        byte_index_next = '0;
      end
    end else if (byte_index == LAST_INDEX) begin
      in_frame_next   = 1'b0;
      byte_index_next = '0;
      if (rx_byte == footer_first || rx_byte == footer_second) begin
        done_next         = 1'b1;
        chan_held_next[0] = {fb[1][2:0], fb[0]};
        chan_held_next[1] = {fb[2][5:0], fb[1][7:3]};
        chan_held_next[2] = {fb[4][0], fb[3], fb[2][7:6]};
        chan_held_next[3] = {fb[5][3:0], fb[4][7:1]};
        left_held_next    = fb[9][3:0];
        right_held_next   = {1'b0, fb[6][3:0]} + 5'd1;
        wheel_held_next   = fb[10];
        if (fb[22] == failsafe_code) begin
          link_alive_next = 1'b0;
        end else begin
          loss_count_next = '0;
          link_alive_next = 1'b1;
        end
      end
    end else begin
      byte_index_next = byte_index + 5'd1;
    end
  end

  always_comb begin
    result_next.frame_done       = done_next;
    result_next.chan_zero        = chan_held_next[0];
    result_next.chan_one         = chan_held_next[1];
    result_next.chan_two         = chan_held_next[2];
    result_next.chan_three       = chan_held_next[3];
    result_next.left_switch_pos  = left_held_next;
    result_next.right_switch_pos = right_held_next;
    result_next.wheel_value      = wheel_held_next;
    result_next.link_ok          = link_alive_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_index <= '0;
      loss_count <= '0;
      link_alive <= 1'b0;
      chan_held  <= '{default: CHAN_RESET};
      left_held  <= '0;
      right_held <= '0;
      wheel_held <= '0;
    end else if (accept) begin
      in_frame   <= in_frame_next;
      byte_index <= byte_index_next;
      loss_count <= loss_count_next;
      link_alive <= link_alive_next;
      chan_held  <= chan_held_next;
      left_held  <= left_held_next;
      right_held <= right_held_next;
      wheel_held <= wheel_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        main_word <= skid_word;
      end else if (accept) begin
        main_word <= result_next;
      end
    end else if (accept) begin
      skid_word <= result_next;
    end
  end

  assign frame_done       = main_word.frame_done;
  assign chan_zero        = main_word.chan_zero;
  assign chan_one         = main_word.chan_one;
  assign chan_two         = main_word.chan_two;
  assign chan_three       = main_word.chan_three;
  assign left_switch_pos  = main_word.left_switch_pos;
  assign right_switch_pos = main_word.right_switch_pos;
  assign wheel_value      = main_word.wheel_value;
  assign link_ok          = main_word.link_ok;

endmodule

/* test/sbus_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame receiver checker
// Watches the register port and both word channels of the frame receiver.
// It keeps its own copy of the decoder state, predicts the result word of
// every accepted input word, and compares each result word field by field.
// ----------------------------------------------------------------------------
module sbus_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sbfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             item_valid,
  input  logic                             item_stall,
  input  logic                             cmd,
  input  logic [7:0]                       rx_byte,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic                             frame_done,
  input  logic [10:0]                      chan_zero,
  input  logic [10:0]                      chan_one,
  input  logic [10:0]                      chan_two,
  input  logic [10:0]                      chan_three,
  input  logic [3:0]                       left_switch_pos,
  input  logic [4:0]                       right_switch_pos,
  input  logic [7:0]                       wheel_value,
  input  logic                             link_ok,
  output int                               fail_count,
  output int                               pending
);

  import sbfr_pkg::*;

  byte_t      foot_a;
  byte_t      foot_b;
  byte_t      lost_code;
  byte_t      lost_limit;
  logic       in_frame;
  index_t     fill_pos;
  byte_t      frame_bytes [FRAME_BYTES];
  byte_t      tick_count;
  logic       alive;
  chan_t      held_ch [4];
  logic [3:0] held_left;
  logic [4:0] held_right;
  byte_t      held_wheel;
  result_t    report_q [$];

  task automatic decode_word(input logic c, input byte_t b);
    result_t r;
    r.frame_done = 1'b0;
    if (c == CMD_TICK) begin
      if (tick_count != COUNT_MAX) tick_count = tick_count + 8'd1;
      if (tick_count > lost_limit) begin
        tick_count = lost_limit;
        alive      = 1'b0;
      end
    end else if (!in_frame) begin
      if (b == HEADER_BYTE) begin
        in_frame = 1'b1;
        fill_pos = '0;
      end
    end else begin
      frame_bytes[fill_pos] = b;
      if (fill_pos == LAST_INDEX) begin
        in_frame = 1'b0;
        fill_pos = '0;
        if (b == foot_a || b == foot_b) begin
          // Channels are packed least significant bit first from byte 0.
          held_ch[0] = chan_t'({frame_bytes[1], frame_bytes[0]});
          held_ch[1] = chan_t'({frame_bytes[2], frame_bytes[1][7:3]});
          held_ch[2] = {frame_bytes[4][0], frame_bytes[3], frame_bytes[2][7:6]};
          held_ch[3] = {frame_bytes[5][3:0], frame_bytes[4][7:1]};
          held_left  = frame_bytes[9][3:0];
          held_right = {1'b0, frame_bytes[6][3:0]} + 5'd1;
          held_wheel = frame_bytes[10];
          if (frame_bytes[FRAME_BYTES-2] == lost_code) begin
            alive = 1'b0;
          end else begin
            tick_count = '0;
            alive      = 1'b1;
          end
          r.frame_done = 1'b1;
        end
      end else begin
        fill_pos = fill_pos + 1'b1;
      end
    end
    r.chan_zero        = held_ch[0];
    r.chan_one         = held_ch[1];
    r.chan_two         = held_ch[2];
    r.chan_three       = held_ch[3];
    r.left_switch_pos  = held_left;
    r.right_switch_pos = held_right;
    r.wheel_value      = held_wheel;
    r.link_ok          = alive;
    report_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foot_a     = FOOTER_FIRST_RESET;
      foot_b     = FOOTER_SECOND_RESET;
      lost_code  = FAILSAFE_RESET;
      lost_limit = LOSS_LIMIT_RESET;
      in_frame   = 1'b0;
      fill_pos   = '0;
      tick_count = '0;
      alive      = 1'b0;
      for (int i = 0; i < 4; i++) held_ch[i] = CHAN_RESET;
      held_left  = '0;
      held_right = '0;
      held_wheel = '0;
      report_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FOOTER_FIRST:  foot_a     = cfg_data;
          REG_FOOTER_SECOND: foot_b     = cfg_data;
          REG_FAILSAFE_CODE: lost_code  = cfg_data;
          REG_LOSS_LIMIT:    lost_limit = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (report_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, actual frame_done %0d",
                   $time, frame_done);
        end else begin
          want = report_q.pop_front();
          check_field("frame_done", 11'(want.frame_done), 11'(frame_done));
          check_field("chan_zero", want.chan_zero, chan_zero);
          check_field("chan_one", want.chan_one, chan_one);
          check_field("chan_two", want.chan_two, chan_two);
          check_field("chan_three", want.chan_three, chan_three);
          check_field("left_switch_pos", 11'(want.left_switch_pos), 11'(left_switch_pos));
          check_field("right_switch_pos", 11'(want.right_switch_pos),
                      11'(right_switch_pos));
          check_field("wheel_value", 11'(want.wheel_value), 11'(wheel_value));
          check_field("link_ok", 11'(want.link_ok), 11'(link_ok));
        end
      end
      if (item_valid && !item_stall) decode_word(cmd, rx_byte);
    end
    pending = report_q.size();
  end

endmodule

/* test/tb_sbus_frame_receiver.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Drives header-framed byte streams, noise and timer ticks into the frame
// receiver under several register settings, with random idling on both
// channels and one long hold-off of the result side. A checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_sbus_frame_receiver;

  import sbfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int FLAG_POS    = FRAME_BYTES - 2;
  localparam logic [CFG_INDEX_W-1:0] SPARE_FIRST = CFG_INDEX_W'(int'(REG_LOSS_LIMIT) + 1);
  localparam logic [CFG_INDEX_W-1:0] SPARE_LAST  = '1;

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [7:0]             cfg_data     = '0;
  logic                   item_valid   = 1'b0;
  logic                   cmd          = 1'b0;
  logic [7:0]             rx_byte      = '0;
  logic                   result_stall = 1'b0;
  logic                   item_stall;
  logic                   result_valid;
  logic                   frame_done;
  logic [10:0]            chan_zero;
  logic [10:0]            chan_one;
  logic [10:0]            chan_two;
  logic [10:0]            chan_three;
  logic [3:0]             left_switch_pos;
  logic [4:0]             right_switch_pos;
  logic [7:0]             wheel_value;
  logic                   link_ok;

  int    fail_count;
  int    pending;
  int    cycle_count = 0;
  int    words_sent  = 0;
  byte_t foot_a_s    = FOOTER_FIRST_RESET;
  byte_t foot_b_s    = FOOTER_SECOND_RESET;
  byte_t code_s      = FAILSAFE_RESET;
  byte_t limit_s     = LOSS_LIMIT_RESET;
  bit    calm        = 1'b0;
  bit    squeeze     = 1'b0;

  sbus_frame_receiver dut (.*);

  sbus_frame_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // The result side stalls in short bursts, and once holds off for a long
  // stretch so that the block fills up and stalls its input.
  initial begin
    int  n;
    bit  squeezed;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        result_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input cmd_t c, input byte_t b);
    bit taken;
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    rx_byte    <= b;
    do begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input byte_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic configure(input byte_t fa, input byte_t fb, input byte_t code,
                           input byte_t limit);
    set_reg(REG_FOOTER_FIRST, fa);
    set_reg(REG_FOOTER_SECOND, fb);
    set_reg(REG_FAILSAFE_CODE, code);
    set_reg(REG_LOSS_LIMIT, limit);
    // A write to an index past the last register must change nothing.
    set_reg(CFG_INDEX_W'($urandom_range(SPARE_FIRST, SPARE_LAST)), byte_t'($urandom));
    cfg_we   <= 1'b0;
    foot_a_s = fa;
    foot_b_s = fb;
    code_s   = code;
    limit_s  = limit;
  endtask

  task automatic send_frame();
    byte_t b;
    int    pick;
    send_word(CMD_BYTE, HEADER_BYTE);
    for (int k = 0; k < FRAME_BYTES; k++) begin
      if ($urandom_range(0, 9) == 0) send_word(CMD_TICK, byte_t'($urandom));
      b = byte_t'($urandom);
      if (k == FLAG_POS && $urandom_range(0, 3) == 0) b = code_s;
      if (k == FRAME_BYTES - 1) begin
        pick = $urandom_range(0, 5);
        if (pick < 3) b = foot_a_s;
        else if (pick < 5) b = foot_b_s;
      end
      send_word(CMD_BYTE, b);
    end
  endtask

  task automatic send_mix(input int target);
    int stop;
    int n;
    int pick;
    stop = words_sent + target;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        send_frame();
      end else if (pick < 17) begin
        n = $urandom_range(1, 3);
        repeat (n) send_word(CMD_BYTE, byte_t'($urandom));
      end else begin
        n = $urandom_range(1, (limit_s < 13) ? int'(limit_s) + 3 : 16);
        repeat (n) send_word(CMD_TICK, byte_t'($urandom));
      end
    end
  endtask

  initial begin
    byte_t fa;
    byte_t limit;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a tick, noise at both extremes, then one full frame
    // of all-ones data, with a zero flag byte, that ends on the first footer.
    send_word(CMD_TICK, 8'hFF);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_BYTE, HEADER_BYTE);
    for (int k = 0; k < FRAME_BYTES; k++) begin
      if (k == FRAME_BYTES - 1) send_word(CMD_BYTE, foot_a_s);
      else if (k == FLAG_POS) send_word(CMD_BYTE, 8'h00);
      else send_word(CMD_BYTE, 8'hFF);
    end
    settle();

    configure(8'h00, 8'hFF, 8'h00, 8'd1);
    send_mix(250);
    settle();

    configure(8'hFF, 8'h00, 8'hFF, 8'd254);
    squeeze = 1'b1;
    send_mix(200);
    repeat (300) send_word(CMD_TICK, byte_t'($urandom));
    send_frame();
    settle();

    // With the limit at its top the counter saturates and the link holds.
    configure(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), COUNT_MAX);
    send_mix(100);
    repeat (300) send_word(CMD_TICK, byte_t'($urandom));
    send_frame();
    settle();

    for (int p = 0; p < 4; p++) begin
      if (p == 3) calm = 1'b1;
      fa    = byte_t'($urandom);
      limit = ($urandom_range(0, 3) == 0) ? byte_t'($urandom_range(1, 254))
                                          : byte_t'($urandom_range(1, 12));
      configure(fa, ($urandom_range(0, 3) == 0) ? fa : byte_t'($urandom),
                byte_t'($urandom), limit);
      send_mix(250);
      settle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sbus_frame_receiver.f */
hw/rtl/sbfr_pkg.sv
hw/rtl/sbfr_byte_cell.sv
hw/rtl/sbfr_byte_chain.sv
hw/rtl/sbus_frame_receiver.sv
test/sbus_frame_checker.sv
test/tb_sbus_frame_receiver.sv
